// ===== rtl/core/integer_field_formatter_defines.svh =====
// Assertion macros shared by the integer field formatter RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define IFF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_field_formatter: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define IFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_field_formatter: next-cycle check failed");

`endif

// ===== rtl/core/iff_pkg.sv =====
// Package for the integer field formatter: widths, mode codes, characters, layout type.
// No dependencies; used by the channel, top-level, digit-unit and emitter files.
`timescale 1ns / 1ps

package iff_pkg;

    // Parameter defaults
    localparam int MAX_FIELD_DEF  = 64;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int VALUE_BITS_DEF = 64;

    // Fixed widths of the beat fields and internal counts
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 64;
    localparam int CNT_W   = 7;   // character counts up to MAX_FIELD (at most 64)
    localparam int LEN_W   = 8;   // unclamped field length
    localparam int ND_W    = 5;   // digit count up to MAX_DIGITS (at most 20)
    localparam int CHAR_W  = 8;

    // Conversion modes
    localparam logic [MODE_W-1:0] MODE_SDEC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UDEC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LHEX = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UHEX = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PTR  = 3'd4;

    // ASCII characters
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // Field layout handed from the top level to the character emitter
    typedef struct packed {
        logic [CNT_W-1:0]  lead_len;    // leading spaces
        logic              sign_en;
        logic [CHAR_W-1:0] sign_char;
        logic              pfx_en;      // "0x" or "0X"
        logic [CHAR_W-1:0] x_char;
        logic [CNT_W-1:0]  zpad_len;    // zero fill after the prefix
        logic [CNT_W-1:0]  prec_len;    // precision zeros
        logic [ND_W-1:0]   dig_len;
        logic [CNT_W-1:0]  trail_len;   // trailing spaces
        logic              upper;
        logic [CNT_W-1:0]  emit_total;  // characters sent, after the cut
    } layout_t;

endpackage

// ===== rtl/core/iff_channels.sv =====
// Valid/ready channel interfaces for the integer field formatter.
// Depends on iff_pkg for the payload widths.
`timescale 1ns / 1ps

// Input channel: one conversion request per beat
interface iff_in_if;
    logic                       valid;
    logic                       ready;
    logic [iff_pkg::MODE_W-1:0] mode;
    logic [iff_pkg::VALUE_W-1:0] value;
    logic                       negative;
    logic [6:0]                 field_width;
    logic signed [6:0]          min_digits;
    logic                       left_just;
    logic                       zero_fill;
    logic                       plus_flag;
    logic                       space_flag;
    logic                       alt_flag;

    modport source (
        output valid, mode, value, negative, field_width, min_digits,
               left_just, zero_fill, plus_flag, space_flag, alt_flag,
        input  ready
    );
    modport sink (
        input  valid, mode, value, negative, field_width, min_digits,
               left_just, zero_fill, plus_flag, space_flag, alt_flag,
        output ready
    );
endinterface

// Output channel: one character per beat
interface iff_out_if;
    logic                        valid;
    logic                        ready;
    logic [iff_pkg::CHAR_W-1:0]  char_out;
    logic                        char_valid;
    logic                        last;
    logic [iff_pkg::CNT_W-1:0]   total_count;

    modport source (
        output valid, char_out, char_valid, last, total_count,
        input  ready
    );
    modport sink (
        input  valid, char_out, char_valid, last, total_count,
        output ready
    );
endinterface

// ===== rtl/core/integer_field_formatter.sv =====
// Top level of the integer field formatter: request capture, field layout, sequencing.
// Depends on iff_pkg, iff_channels, iff_digit_unit and iff_emitter.
`timescale 1ns / 1ps

`include "integer_field_formatter_defines.svh"

// Formats one integer per request beat on "item" as printf-style text and sends
// it on "result", one character per beat, last set on the final character, which
// also carries the character count. An item that yields no text gives a single
// beat with char_valid low, last high and a count of zero.
// Timing: a decimal item runs through the shift-add-3 digit unit,
// one bit per cycle; hex and pointer items load their digits directly. After
// the layout and launch states, characters go out one per cycle while the
// receiver is ready, pausing at each segment change, and item.ready stays low
// from acceptance until its last beat sits in the output register. A stalled
// receiver holds the output register and stops the emitter; the next request
// can still be taken while the final beat waits.
// Reset (rst_n low, asynchronous) empties the output stage and returns to idle.

module integer_field_formatter #(
    parameter int MAX_FIELD  = iff_pkg::MAX_FIELD_DEF,
    parameter int MAX_DIGITS = iff_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    iff_in_if.sink     item,
    iff_out_if.source  result
);
    import iff_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CONV   = 2'd1;
    localparam logic [1:0] S_LAYOUT = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic                    accept;

    // Captured request
    logic [MODE_W-1:0]       mode_reg;
    logic                    neg_reg;
    logic [6:0]              width_reg;
    logic [6:0]              prec_raw_reg;
    logic                    left_reg;
    logic                    zfill_reg;
    logic                    plus_reg;
    logic                    space_reg;
    logic                    alt_reg;
    logic                    vzero_reg;

    logic [VALUE_BITS-1:0]   value_m;
    logic                    hex_in;
    logic                    dig_done;
    logic [MAX_DIGITS*4-1:0] digits;
    logic [ND_W-1:0]         nd;
    logic                    emit_start;
    logic                    emit_done;
    layout_t                 lay;

    // Layout terms
    logic                    is_ptr;
    logic                    sdec_mode;
    logic                    is_xhex;
    logic                    has_prec;
    logic [CNT_W-1:0]        width_c;
    logic [CNT_W-1:0]        prec_c;
    logic [ND_W-1:0]         nd_eff;
    logic [CNT_W-1:0]        prec_pad;
    logic [1:0]              pre_len;
    logic [LEN_W-1:0]        content;
    logic [LEN_W-1:0]        full;
    logic [CNT_W-1:0]        wpad;
    logic                    zfill_on;

    assign accept  = item.valid && item.ready;
    assign value_m = item.value[VALUE_BITS-1:0];
    assign hex_in  = (item.mode == MODE_LHEX) || (item.mode == MODE_UHEX)
                  || (item.mode == MODE_PTR);

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= item.mode;
            neg_reg      <= item.negative;
            width_reg    <= item.field_width;
            prec_raw_reg <= item.min_digits;
            left_reg     <= item.left_just;
            zfill_reg    <= item.zero_fill;
            plus_reg     <= item.plus_flag;
            space_reg    <= item.space_flag;
            alt_reg      <= item.alt_flag;
            vzero_reg    <= (value_m == '0);
        end
    end

    // Field layout from the captured request and the digit count
    always_comb
    begin
        is_ptr    = (mode_reg == MODE_PTR);
        sdec_mode = (mode_reg == MODE_SDEC);
        is_xhex   = (mode_reg == MODE_LHEX) || (mode_reg == MODE_UHEX);
        has_prec  = !prec_raw_reg[6] && !is_ptr;
        width_c   = (width_reg > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : width_reg;
        prec_c    = !has_prec ? '0
                  : (prec_raw_reg > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : prec_raw_reg;

        // zero with precision zero prints no digits
        nd_eff   = (vzero_reg && has_prec && prec_c == '0) ? '0 : nd;
        prec_pad = (prec_c > CNT_W'(nd_eff)) ? prec_c - CNT_W'(nd_eff) : '0;

        lay           = '0;
        lay.upper     = (mode_reg == MODE_UHEX);
        lay.x_char    = lay.upper ? CH_UX : CH_LX;
        lay.pfx_en    = is_ptr || (is_xhex && alt_reg && !vzero_reg);
        lay.sign_char = CH_SPACE;
        if (sdec_mode)
        begin
            if (neg_reg)
            begin
                lay.sign_en   = 1'b1;
                lay.sign_char = CH_MINUS;
            end
            else if (plus_reg)
            begin
                lay.sign_en   = 1'b1;
                lay.sign_char = CH_PLUS;
            end
            else if (space_reg)
            begin
                lay.sign_en   = 1'b1;
                lay.sign_char = CH_SPACE;
            end
        end
        pre_len = lay.pfx_en ? 2'd2 : {1'b0, lay.sign_en};

        content  = LEN_W'(nd_eff) + LEN_W'(prec_pad) + LEN_W'(pre_len);
        wpad     = (LEN_W'(width_c) > content) ? CNT_W'(LEN_W'(width_c) - content) : '0;
        full     = (LEN_W'(width_c) > content) ? LEN_W'(width_c) : content;
        zfill_on = !is_ptr && !left_reg && zfill_reg && !has_prec;

        lay.lead_len   = (!left_reg && !zfill_on) ? wpad : '0;
        lay.zpad_len   = zfill_on ? wpad : '0;
        lay.prec_len   = prec_pad;
        lay.dig_len    = nd_eff;
        lay.trail_len  = left_reg ? wpad : '0;
        lay.emit_total = (full > LEN_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(full);
    end

    // Item sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_CONV;
            S_CONV:   if (dig_done) state_next = S_LAYOUT;
            S_LAYOUT: state_next = S_EMIT;
            S_EMIT:   if (emit_done) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item.ready = (state_reg == S_IDLE);
    assign emit_start = (state_reg == S_LAYOUT);

    iff_digit_unit #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_digits (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .hex    (hex_in),
        .value  (value_m),
        .done   (dig_done),
        .digits (digits),
        .nd     (nd)
    );

    iff_emitter #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (emit_start),
        .lay    (lay),
        .digits (digits),
        .done   (emit_done),
        .result (result)
    );

    // Digit unit finishes only for the item being converted
    `IFF_ASSERT_IMPL(a_done_in_conv, dig_done, state_reg == S_CONV)
    // Layout is handed over and emission follows in the next cycle
    `IFF_ASSERT_NEXT(a_layout_to_emit, state_reg == S_LAYOUT, state_reg == S_EMIT)
    // Emitter completion belongs to the item in flight
    `IFF_ASSERT_IMPL(a_emit_done_owner, emit_done, state_reg == S_EMIT)

endmodule

// ===== rtl/core/iff_digit_unit.sv =====
// Digit extraction for the integer field formatter: shift-add-3 binary to BCD,
// one value bit per cycle, or a direct nibble load for hex. Depends on iff_pkg.
`timescale 1ns / 1ps

module iff_digit_unit #(
    parameter int MAX_DIGITS = iff_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          hex,
    input  logic [VALUE_BITS-1:0]         value,
    output logic                          done,
    output logic [MAX_DIGITS*4-1:0]       digits,
    output logic [iff_pkg::ND_W-1:0]      nd
);
    import iff_pkg::*;

    localparam int DIG_W = MAX_DIGITS * 4;
    localparam int BIT_W = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_SHIFT = 2'd1;
    localparam logic [1:0] D_DONE  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [BIT_W-1:0]      bits_reg, bits_next;
    logic                  ovf_reg, ovf_next;
    logic [DIG_W-1:0]      bcd_reg, bcd_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [DIG_W-1:0]      adj;

    // Add 3 to every digit of 5 or more, ahead of the doubling shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        bits_next  = bits_reg;
        ovf_next   = ovf_reg;
        bcd_next   = bcd_reg;
        shift_next = shift_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    ovf_next   = 1'b0;
                    shift_next = value;
                    bits_next  = BIT_W'(VALUE_BITS);
                    if (hex)
                    begin
                        bcd_next   = DIG_W'(value);
                        state_next = D_DONE;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        state_next = D_SHIFT;
                    end
                end
            end
            D_SHIFT:
            begin
                // the bit shifted out of the top digit is dropped; remember it was there
                bcd_next   = {adj[DIG_W-2:0], shift_reg[VALUE_BITS-1]};
                ovf_next   = ovf_reg | adj[DIG_W-1];
                shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
                bits_next  = bits_reg - 1'b1;
                if (bits_reg == BIT_W'(1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            bits_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bits_reg  <= bits_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Digit and value shifters
    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        shift_reg <= shift_next;
    end

    // Significant digits: highest nonzero digit, at least one, all when overflowed
    always_comb
    begin
        nd = ND_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                nd = ND_W'(i + 1);
            end
        end
        if (ovf_reg)
        begin
            nd = ND_W'(MAX_DIGITS);
        end
    end

    assign done   = (state_reg == D_DONE);
    assign digits = bcd_reg;

endmodule

// ===== rtl/core/iff_emitter.sv =====
// Character emitter for the integer field formatter: walks the field segments and
// sends one character per beat through a registered output stage. Depends on iff_pkg.
`timescale 1ns / 1ps

`include "integer_field_formatter_defines.svh"

module iff_emitter #(
    parameter int MAX_DIGITS = iff_pkg::MAX_DIGITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  iff_pkg::layout_t        lay,
    input  logic [MAX_DIGITS*4-1:0] digits,
    output logic                    done,
    iff_out_if.source               result
);
    import iff_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIGITS);

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_RUN   = 2'd1;
    localparam logic [1:0] E_EMPTY = 2'd2;

    localparam logic [2:0] SEG_LEAD  = 3'd0;
    localparam logic [2:0] SEG_SIGN  = 3'd1;
    localparam logic [2:0] SEG_PFX   = 3'd2;
    localparam logic [2:0] SEG_ZPAD  = 3'd3;
    localparam logic [2:0] SEG_PREC  = 3'd4;
    localparam logic [2:0] SEG_DIG   = 3'd5;
    localparam logic [2:0] SEG_TRAIL = 3'd6;
    localparam logic [2:0] SEG_END   = 3'd7;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        seg_reg, seg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    layout_t           lay_reg;

    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              cv_reg, cv_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  tot_reg, tot_next;

    logic              slot_free;
    logic              is_last;
    logic [CNT_W-1:0]  dig_sel;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] dig_char;
    logic [CHAR_W-1:0] cur_char;

    // Length of one segment of the field
    function automatic logic [CNT_W-1:0] seg_len(input logic [2:0] seg, input layout_t l);
        logic [CNT_W-1:0] len;
        begin
            unique case (seg)
                SEG_LEAD:  len = l.lead_len;
                SEG_SIGN:  len = CNT_W'(l.sign_en);
                SEG_PFX:   len = l.pfx_en ? CNT_W'(2) : CNT_W'(0);
                SEG_ZPAD:  len = l.zpad_len;
                SEG_PREC:  len = l.prec_len;
                SEG_DIG:   len = CNT_W'(l.dig_len);
                SEG_TRAIL: len = l.trail_len;
                default:   len = '0;
            endcase
            return len;
        end
    endfunction

    assign slot_free = !ov_reg || result.ready;
    assign is_last   = (k_reg + 1'b1) == lay_reg.emit_total;

    // Digit character, most significant first
    assign dig_sel  = cnt_reg - 1'b1;
    assign nib      = digits[{dig_sel[IDX_W-1:0], 2'b00} +: 4];
    assign dig_char = (nib < 4'd10) ? CH_ZERO + CHAR_W'(nib)
                                    : (lay_reg.upper ? CH_UA : CH_LA) + CHAR_W'(nib - 4'd10);

    // Character of the current segment
    always_comb
    begin
        case (seg_reg)
            SEG_SIGN: cur_char = lay_reg.sign_char;
            SEG_PFX:  cur_char = (cnt_reg == CNT_W'(2)) ? CH_ZERO : lay_reg.x_char;
            SEG_ZPAD,
            SEG_PREC: cur_char = CH_ZERO;
            SEG_DIG:  cur_char = dig_char;
            default:  cur_char = CH_SPACE;
        endcase
    end

    // Segment sequencer and output stage
    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        ov_next    = ov_reg && !result.ready;
        char_next  = char_reg;
        cv_next    = cv_reg;
        last_next  = last_reg;
        tot_next   = tot_reg;
        done       = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    seg_next   = SEG_LEAD;
                    cnt_next   = lay.lead_len;
                    k_next     = '0;
                    state_next = (lay.emit_total == '0) ? E_EMPTY : E_RUN;
                end
            end
            E_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    // segment used up or empty: move on, no beat this cycle
                    seg_next = seg_reg + 1'b1;
                    cnt_next = seg_len(seg_reg + 1'b1, lay_reg);
                    if (seg_reg + 1'b1 == SEG_END)
                    begin
                        done       = 1'b1;
                        state_next = E_IDLE;
                    end
                end
                else if (slot_free)
                begin
                    ov_next   = 1'b1;
                    char_next = cur_char;
                    cv_next   = 1'b1;
                    last_next = is_last;
                    tot_next  = is_last ? lay_reg.emit_total : '0;
                    cnt_next  = cnt_reg - 1'b1;
                    k_next    = k_reg + 1'b1;
                    if (is_last)
                    begin
                        done       = 1'b1;
                        state_next = E_IDLE;
                    end
                end
            end
            E_EMPTY:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    char_next  = CH_NONE;
                    cv_next    = 1'b0;
                    last_next  = 1'b1;
                    tot_next   = '0;
                    done       = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            seg_reg   <= SEG_LEAD;
            cnt_reg   <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    // Layout and beat payload
    always_ff @(posedge clk)
    begin
        if (start && state_reg == E_IDLE)
        begin
            lay_reg <= lay;
        end
        char_reg <= char_next;
        cv_reg   <= cv_next;
        last_reg <= last_next;
        tot_reg  <= tot_next;
    end

    assign result.valid       = ov_reg;
    assign result.char_out    = char_reg;
    assign result.char_valid  = cv_reg;
    assign result.last        = last_reg;
    assign result.total_count = tot_reg;

    // Only the final beat of an item carries the count; others are real characters
    `IFF_ASSERT_IMPL(a_count_on_last, ov_reg && !last_reg, cv_reg && tot_reg == '0)
    // The character index never reaches the item's total while running
    `IFF_ASSERT_IMPL(a_index_bound, state_reg == E_RUN, k_reg < lay_reg.emit_total)
    // Digit selection stays inside the digit register
    `IFF_ASSERT_IMPL(a_digit_index, state_reg == E_RUN && seg_reg == SEG_DIG, cnt_reg <= CNT_W'(MAX_DIGITS))

endmodule
